FILE: rtl/core/bsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

   // point store and field sizes
   localparam int MAX_POINTS  = 1024;
   localparam int COORD_W     = 16;
   localparam int CENTER_W    = COORD_W + 1;
   localparam int RADIUS_W    = COORD_W + 2;
   localparam int DIFF_W      = COORD_W + 2;
   localparam int SQ_W        = 2 * DIFF_W - 2;
   localparam int DIST_W      = 2 * RADIUS_W;
   localparam int REM_W       = RADIUS_W + 3;
   localparam int ADDR_W      = $clog2(MAX_POINTS);
   localparam int COUNT_W     = $clog2(MAX_POINTS + 1);
   localparam int ROOT_CNT_W  = $clog2(RADIUS_W);

   // word queue between loader and scanner
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // one word handed from the loader to the scanner
   typedef struct packed {
      logic                               store_en;
      logic                               end_en;
      logic [ADDR_W-1:0]                  addr;
      logic [COUNT_W-1:0]                 count;
      logic [2:0][COORD_W-1:0]            pt;
      logic [2:0][CENTER_W-1:0]           c2;
   } cmd_word_type;

   // queue status seen by both sides
   typedef struct packed {
      logic                               full;
      logic                               empty;
      logic [QUEUE_PTR_W:0]               level;
   } queue_status_type;

   // scanner sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ROOT,
      ST_SEND
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/bounding_sphere_from_points_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounding sphere of a point cloud, centred on the midpoint of its box.
// Input: one point per word on req_point_x/y/z, req_last_point marks the
// final point of a cloud. A word is taken at a clock edge with start high
// and busy low. Points load at one per cycle into a four-word queue; busy
// rises only while that queue is full.
// Output: after the last point one result word, rsp_strobe high for exactly
// one cycle with the doubled centre and doubled radius. The receiver cannot
// stall; the word must be taken in that cycle.
// After the last point is popped, the scanner re-reads each stored
// point (one per cycle, three-stage square and compare) from its store,
// which has a write port and a separate read port; then a bit-serial
// square root runs. Points of the next cloud queue up meanwhile and stall
// at busy once four words wait.
// At most 1024 points are kept; later points of a cloud are dropped but a
// last flag still ends the cloud.
// Reset (synchronous) empties the queue and clears the box and the count.
module bounding_sphere_from_points_unit
   import bsp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic [COORD_W-1:0]   req_point_x,
   input  wire logic [COORD_W-1:0]   req_point_y,
   input  wire logic [COORD_W-1:0]   req_point_z,
   input  wire logic                 req_last_point,
   output      logic                 rsp_strobe,
   output      logic [CENTER_W-1:0]  rsp_center_x_doubled,
   output      logic [CENTER_W-1:0]  rsp_center_y_doubled,
   output      logic [CENTER_W-1:0]  rsp_center_z_doubled,
   output      logic [RADIUS_W-1:0]  rsp_radius_doubled
);

   logic             accept;
   logic             push;
   logic             pop;
   cmd_word_type     push_word;
   cmd_word_type     pop_word;
   queue_status_type q_status;

   assign busy   = q_status.full;
   assign accept = start && !busy;

   bsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .point_z    (req_point_z),
      .last_point (req_last_point),
      .push       (push),
      .word       (push_word)
   );

   bsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .status    (q_status)
   );

   bsp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .word                 (pop_word),
      .empty                (q_status.empty),
      .pop                  (pop),
      .rsp_strobe           (rsp_strobe),
      .rsp_center_x_doubled (rsp_center_x_doubled),
      .rsp_center_y_doubled (rsp_center_y_doubled),
      .rsp_center_z_doubled (rsp_center_z_doubled),
      .rsp_radius_doubled   (rsp_radius_doubled)
   );

   // a result never lasts more than one cycle
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // the scanner never pops an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // the queue level stays within its depth
   assert property (@(posedge clock) disable iff (reset)
                    q_status.level <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
      else $error("queue level beyond depth");

   // a pushed word raises the level unless one was popped
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> (q_status.level == $past(q_status.level) + 1'b1))
      else $error("queue level did not follow a push");

endmodule

`default_nettype wire

FILE: rtl/core/bsp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bsp_front
   import bsp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [COORD_W-1:0]  point_x,
   input  wire logic [COORD_W-1:0]  point_y,
   input  wire logic [COORD_W-1:0]  point_z,
   input  wire logic                last_point,
   output      logic                push,
   output      cmd_word_type        word
);

   logic signed [COORD_W-1:0] min_ff [3];
   logic signed [COORD_W-1:0] max_ff [3];
   logic signed [COORD_W-1:0] min_in [3];
   logic signed [COORD_W-1:0] max_in [3];
   logic signed [COORD_W-1:0] min_sel [3];
   logic signed [COORD_W-1:0] max_sel [3];
   logic [COUNT_W-1:0]        count_ff;
   logic [COORD_W-1:0]        pt [3];
   logic                      store_en;

   assign pt[0] = point_x;
   assign pt[1] = point_y;
   assign pt[2] = point_z;

   // classify the word: store while room remains, end on the last point
   assign store_en = (count_ff < COUNT_W'(MAX_POINTS));

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         min_in[j] = ($signed(pt[j]) < min_ff[j]) ? $signed(pt[j]) : min_ff[j];
         max_in[j] = ($signed(pt[j]) > max_ff[j]) ? $signed(pt[j]) : max_ff[j];
         min_sel[j] = store_en ? min_in[j] : min_ff[j];
         max_sel[j] = store_en ? max_in[j] : max_ff[j];
      end
   end

   // build the word for the scanner
   always_comb begin
      word.store_en = store_en;
      word.end_en   = last_point;
      word.addr     = count_ff[ADDR_W-1:0];
      word.count    = store_en ? count_ff + COUNT_W'(1) : count_ff;
      for (int j = 0; j < 3; j++) begin
         word.pt[j] = pt[j];
         word.c2[j] = CENTER_W'($signed({min_sel[j][COORD_W-1], min_sel[j]})
                                + $signed({max_sel[j][COORD_W-1], max_sel[j]}));
      end
   end

   assign push = accept && (store_en || last_point);

   // track the box; clear it when a cloud ends
   always_ff @(posedge clock) begin
      if (reset || (accept && last_point)) begin
         count_ff <= '0;
         for (int j = 0; j < 3; j++) begin
            min_ff[j] <= {1'b0, {(COORD_W-1){1'b1}}};
            max_ff[j] <= {1'b1, {(COORD_W-1){1'b0}}};
         end
      end else if (accept && store_en) begin
         count_ff <= count_ff + COUNT_W'(1);
         for (int j = 0; j < 3; j++) begin
            min_ff[j] <= min_in[j];
            max_ff[j] <= max_in[j];
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/bsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bsp_queue
   import bsp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire cmd_word_type push_word,
   input  wire logic         pop,
   output      cmd_word_type pop_word,
   output      queue_status_type status
);

   cmd_word_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W:0]     level_ff;

   assign status.full  = (level_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (level_ff == '0);
   assign status.level = level_ff;
   assign pop_word     = slot_ff[rd_ptr_ff];

   // hold the words
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   // advance the pointers and the fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + (QUEUE_PTR_W+1)'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - (QUEUE_PTR_W+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/bsp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bsp_back
   import bsp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_word_type         word,
   input  wire logic                 empty,
   output      logic                 pop,
   output      logic                 rsp_strobe,
   output      logic [CENTER_W-1:0]  rsp_center_x_doubled,
   output      logic [CENTER_W-1:0]  rsp_center_y_doubled,
   output      logic [CENTER_W-1:0]  rsp_center_z_doubled,
   output      logic [RADIUS_W-1:0]  rsp_radius_doubled
);

   back_state_type             state_ff;
   back_state_type             state_in;

   logic [2:0][COORD_W-1:0]    store_mem [MAX_POINTS];
   logic [2:0][COORD_W-1:0]    rd_data_ff;
   logic [2:0][CENTER_W-1:0]   c2_ff;
   logic [COUNT_W-1:0]         cnt_ff;
   logic [COUNT_W-1:0]         rd_idx_ff;
   logic                       rd_v_ff;
   logic                       sq_v_ff;
   logic [SQ_W-1:0]            sq_ff [3];
   logic [DIST_W-1:0]          best_ff;
   logic [DIST_W-1:0]          dist_sum;

   logic [DIST_W-1:0]          x_ff;
   logic [REM_W-1:0]           rem_ff;
   logic [RADIUS_W-1:0]        root_ff;
   logic [ROOT_CNT_W-1:0]      step_ff;
   logic [REM_W-1:0]           rem_sh;
   logic [REM_W-1:0]           trial;

   logic signed [DIFF_W-1:0]   diff [3];
   logic signed [2*DIFF_W-1:0] prod [3];

   logic                       issue;
   logic                       scan_done;
   logic                       root_done;
   logic                       start_scan;

   assign scan_done = (rd_idx_ff == cnt_ff) && !rd_v_ff && !sq_v_ff;
   assign root_done = (step_ff == ROOT_CNT_W'(RADIUS_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!empty && word.end_en) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      pop        = 1'b0;
      issue      = 1'b0;
      rsp_strobe = 1'b0;
      start_scan = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            pop        = !empty;
            start_scan = !empty && word.end_en;
         end
         ST_SCAN: begin
            issue = (rd_idx_ff != cnt_ff);
         end
         ST_ROOT: begin
         end
         ST_SEND: begin
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // point store: write from the queue, registered read for the scan
   always_ff @(posedge clock) begin
      if (pop && word.store_en) begin
         store_mem[word.addr] <= word.pt;
      end
      rd_data_ff <= store_mem[rd_idx_ff[ADDR_W-1:0]];
   end

   // doubled distance per axis and its square
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         diff[j] = $signed({rd_data_ff[j][COORD_W-1], rd_data_ff[j], 1'b0})
                 - $signed({c2_ff[j][CENTER_W-1], c2_ff[j]});
         prod[j] = diff[j] * diff[j];
      end
   end

   assign dist_sum = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);

   // scan pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         rd_v_ff   <= 1'b0;
         sq_v_ff   <= 1'b0;
      end else begin
         rd_v_ff <= issue;
         sq_v_ff <= rd_v_ff;
         if (start_scan) begin
            rd_idx_ff <= '0;
         end else if (issue) begin
            rd_idx_ff <= rd_idx_ff + COUNT_W'(1);
         end
      end
   end

   // latch the job, square, keep the largest distance
   always_ff @(posedge clock) begin
      if (start_scan) begin
         c2_ff   <= word.c2;
         cnt_ff  <= word.count;
         best_ff <= '0;
      end else if (sq_v_ff && (dist_sum > best_ff)) begin
         best_ff <= dist_sum;
      end
      for (int j = 0; j < 3; j++) begin
         sq_ff[j] <= prod[j][SQ_W-1:0];
      end
   end

   // square root, one result bit per cycle
   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], x_ff[DIST_W-1 -: 2]};
      trial  = REM_W'({root_ff, 2'b01});
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN) begin
         x_ff    <= best_ff;
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end else if (state_ff == ST_ROOT) begin
         x_ff    <= {x_ff[DIST_W-3:0], 2'b00};
         step_ff <= step_ff + ROOT_CNT_W'(1);
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[RADIUS_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[RADIUS_W-2:0], 1'b0};
         end
      end
   end

   // result word
   assign rsp_center_x_doubled = c2_ff[0];
   assign rsp_center_y_doubled = c2_ff[1];
   assign rsp_center_z_doubled = c2_ff[2];
   assign rsp_radius_doubled   = root_ff;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bsp_pkg::*;

   localparam int ITEM_TARGET    = 1250;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int CALM_FROM      = 600;
   localparam int CALM_TO        = 900;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               last;
   } point_word_type;

   typedef struct packed {
      logic [CENTER_W-1:0] cx;
      logic [CENTER_W-1:0] cy;
      logic [CENTER_W-1:0] cz;
      logic [RADIUS_W-1:0] radius;
   } sphere_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [COORD_W-1:0]  req_point_x = '0;
   logic [COORD_W-1:0]  req_point_y = '0;
   logic [COORD_W-1:0]  req_point_z = '0;
   logic                req_last_point = 1'b0;
   logic                rsp_strobe;
   logic [CENTER_W-1:0] rsp_center_x_doubled;
   logic [CENTER_W-1:0] rsp_center_y_doubled;
   logic [CENTER_W-1:0] rsp_center_z_doubled;
   logic [RADIUS_W-1:0] rsp_radius_doubled;

   point_word_type  pending_points[$];
   sphere_word_type expected_spheres[$];
   point_word_type  next_word;
   sphere_word_type got_sphere;
   sphere_word_type want_sphere;
   int              words_sent = 0;
   int              failures = 0;
   int              quiet_cycles = 0;

   // predictor state: stored cloud and its running box
   logic signed [COORD_W-1:0] cloud_pts [0:MAX_POINTS-1][0:2];
   logic signed [COORD_W-1:0] box_lo [0:2];
   logic signed [COORD_W-1:0] box_hi [0:2];
   int                        cloud_size;

   bounding_sphere_from_points_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_point_x          (req_point_x),
      .req_point_y          (req_point_y),
      .req_point_z          (req_point_z),
      .req_last_point       (req_last_point),
      .rsp_strobe           (rsp_strobe),
      .rsp_center_x_doubled (rsp_center_x_doubled),
      .rsp_center_y_doubled (rsp_center_y_doubled),
      .rsp_center_z_doubled (rsp_center_z_doubled),
      .rsp_radius_doubled   (rsp_radius_doubled)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // empty the cloud and open the box inside out
   task automatic clear_cloud;
      cloud_size = 0;
      for (int j = 0; j < 3; j++) begin
         box_lo[j] = {1'b0, {(COORD_W-1){1'b1}}};
         box_hi[j] = {1'b1, {(COORD_W-1){1'b0}}};
      end
   endtask

   // floor square root, one result bit per pass from the top
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = RADIUS_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   // store one point, widen the box, and on the last point work out the sphere
   task automatic fold_point_into_sphere(input point_word_type w);
      logic signed [COORD_W-1:0] p [0:2];
      longint                    c2 [0:2];
      longint                    d;
      longint unsigned           dist_sq;
      longint unsigned           widest;
      sphere_word_type           s;
      p[0] = w.x;
      p[1] = w.y;
      p[2] = w.z;
      // drop points once the store is full
      if (cloud_size < MAX_POINTS) begin
         for (int j = 0; j < 3; j++) begin
            cloud_pts[cloud_size][j] = p[j];
            if (p[j] > box_hi[j])
               box_hi[j] = p[j];
            if (p[j] < box_lo[j])
               box_lo[j] = p[j];
         end
         cloud_size++;
      end
      if (w.last) begin
         for (int j = 0; j < 3; j++)
            c2[j] = longint'(box_lo[j]) + longint'(box_hi[j]);
         widest = 0;
         for (int i = 0; i < cloud_size; i++) begin
            dist_sq = 0;
            for (int j = 0; j < 3; j++) begin
               d = 2 * longint'(cloud_pts[i][j]) - c2[j];
               dist_sq += longint'(d * d);
            end
            if (dist_sq > widest)
               widest = dist_sq;
         end
         s.cx = c2[0][CENTER_W-1:0];
         s.cy = c2[1][CENTER_W-1:0];
         s.cz = c2[2][CENTER_W-1:0];
         s.radius = RADIUS_W'(floor_root(widest));
         expected_spheres.push_back(s);
         clear_cloud();
      end
   endtask

   task automatic queue_point(input int x, input int y, input int z, input bit last);
      point_word_type w;
      w.x = x[COORD_W-1:0];
      w.y = y[COORD_W-1:0];
      w.z = z[COORD_W-1:0];
      w.last = last;
      pending_points.push_back(w);
   endtask

   // mix of full range, extremes and tight clusters
   function automatic int random_coord(input int hub);
      case ($urandom_range(0, 7))
         0:       return -32768;
         1:       return 32767;
         2:       return hub + $urandom_range(0, 64) - 32;
         3:       return $urandom_range(0, 200) - 100;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   task automatic queue_random_cloud(input int size);
      int hub;
      hub = $urandom_range(0, 60000) - 30000;
      for (int i = 0; i < size; i++)
         queue_point(random_coord(hub), random_coord(hub), random_coord(hub), i == size - 1);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // driver: hold a word until taken, then advance or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            fold_point_into_sphere({req_point_x, req_point_y, req_point_z, req_last_point});
            words_sent++;
         end
         if (!start || !busy) begin
            if (pending_points.size() != 0 &&
                !((words_sent < CALM_FROM || words_sent >= CALM_TO) &&
                  $urandom_range(0, 99) < 13)) begin
               next_word = pending_points.pop_front();
               start          <= 1'b1;
               req_point_x    <= next_word.x;
               req_point_y    <= next_word.y;
               req_point_z    <= next_word.z;
               req_last_point <= next_word.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: take each strobed word and match it against the oldest sphere
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_sphere = {rsp_center_x_doubled, rsp_center_y_doubled,
                       rsp_center_z_doubled, rsp_radius_doubled};
         if (expected_spheres.size() == 0) begin
            $display("%0t: unexpected result: centre %0d %0d %0d radius %0d", $time,
                     $signed(got_sphere.cx), $signed(got_sphere.cy),
                     $signed(got_sphere.cz), got_sphere.radius);
            failures++;
         end else begin
            want_sphere = expected_spheres.pop_front();
            check_field("centre x", $signed(want_sphere.cx), $signed(got_sphere.cx));
            check_field("centre y", $signed(want_sphere.cy), $signed(got_sphere.cy));
            check_field("centre z", $signed(want_sphere.cz), $signed(got_sphere.cz));
            check_field("radius", want_sphere.radius, got_sphere.radius);
         end
      end
   end

   // watchdog: count cycles in which no word moves either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bounding_sphere_from_points_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int random_words;
      int size;
      bit overfilled;
      clear_cloud();

      // single points at the corners and at the origin
      queue_point(32767, 32767, 32767, 1'b1);
      queue_point(-32768, -32768, -32768, 1'b1);
      queue_point(0, 0, 0, 1'b1);
      // opposite corners: widest box, largest radius
      queue_point(-32768, -32768, -32768, 1'b0);
      queue_point(32767, 32767, 32767, 1'b1);
      queue_point(-32768, 32767, -32768, 1'b0);
      queue_point(32767, -32768, 32767, 1'b1);
      // first point moves min and max together, later ones move one side each
      queue_point(5, 5, 5, 1'b0);
      queue_point(10, -3, 7, 1'b0);
      queue_point(-20, 40, 0, 1'b0);
      queue_point(3, 2, -9, 1'b1);
      // interior points never touch the box
      queue_point(-100, -100, -100, 1'b0);
      queue_point(100, 100, 100, 1'b0);
      queue_point(0, 1, -1, 1'b0);
      queue_point(50, -50, 25, 1'b1);

      // random clouds, one overfilling the store with its last flag on a dropped point
      random_words = 0;
      overfilled = 1'b0;
      while (random_words < ITEM_TARGET) begin
         if (!overfilled && random_words >= 150) begin
            size = MAX_POINTS + 3;
            overfilled = 1'b1;
         end else if ($urandom_range(0, 9) == 0)
            size = $urandom_range(9, 40);
         else
            size = $urandom_range(1, 8);
         queue_random_cloud(size);
         random_words += size;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wait for the last word to go in and the last sphere to come out
      while (pending_points.size() != 0 || start)
         @(posedge clock);
      while (expected_spheres.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("bounding_sphere_from_points_unit: match");
      else
         $display("bounding_sphere_from_points_unit: mismatch");
      $finish;
   end

endmodule
